@@ src/xmie_pkg.sv @@
package xmie_pkg;

  localparam int ADDRESS_WIDTH_DEFAULT = 32;
  localparam int MAX_BYTES = 7;
  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_BYTES);
  localparam int FIFO_DEPTH = 2;

  localparam logic [23:0] MOV_STORE = 24'h000089;
  localparam logic [23:0] MOV_LOAD = 24'h00008B;
  localparam logic [7:0] PREFIX_0F = 8'h0F;
  localparam logic [3:0] FORM_PLAIN = 4'h0;
  localparam logic [3:0] FORM_FIXED_REG = 4'h1;
  localparam logic [3:0] FORM_OPC_ONLY = 4'h2;
  localparam logic [2:0] REG_EBX = 3'd3;
  localparam logic [2:0] REG_EBP = 3'd5;

  localparam logic CFG_RELOAD_ELISION = 1'b0;
  localparam logic CFG_STATE_BASE = 1'b1;

  typedef enum logic [1:0] {
    OP_RAW = 2'd0,
    OP_READ = 2'd1,
    OP_WRITE = 2'd2,
    OP_REG_REG = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_BASE = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_ABS = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MOD_INDIRECT = 2'd0,
    MOD_DISP8 = 2'd1,
    MOD_DISP32 = 2'd2,
    MOD_REGISTER = 2'd3
  } mod_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ src/xmie_front.sv @@
module xmie_front #(
  parameter int ADDRESS_WIDTH = xmie_pkg::ADDRESS_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          op,
  input  logic [23:0]         opcode,
  input  logic [2:0]          reg_field,
  input  logic [1:0]          base_kind,
  input  logic [2:0]          base_reg,
  input  logic [31:0]         offset,
  input  logic                elide_en,
  input  logic [31:0]         state_base,
  output logic                push,
  output xmie_pkg::entry_t    entry
);
  import xmie_pkg::*;

  logic [ADDRESS_WIDTH-1:0] pos_r, pos_nxt;
  logic [ADDRESS_WIDTH-1:0] store_end_r, store_end_nxt;
  logic store_valid_r, store_valid_nxt;
  logic at_end_r, at_end_nxt;
  logic [2:0] trk_reg_r, trk_reg_nxt;
  kind_t trk_kind_r, trk_kind_nxt;
  logic [2:0] trk_breg_r, trk_breg_nxt;
  logic [31:0] trk_off_r, trk_off_nxt;

  logic [23:0] opc, e_opc;
  kind_t kind, e_kind;
  logic [31:0] offs, e_off, disp;
  logic [2:0] e_reg, e_breg, mreg, rm;
  logic drop_self, match, elide_same, elide_move, emit;
  logic has_modrm, fits8, far;
  mod_t modv;
  logic [2:0] dsz;
  logic [MAX_BYTES-1:0][7:0] b;
  logic [CNT_W-1:0] n;

  always_comb begin
    opc = opcode;
    unique case (op_t'(op))
      OP_READ: opc[1] = 1'b1;
      OP_WRITE: opc[1] = 1'b0;
      OP_REG_REG: begin
        if (opcode[15:12] == FORM_PLAIN) opc[1] = 1'b0;
      end
      default: opc = opcode;
    endcase
    drop_self = (op_t'(op) == OP_REG_REG) && (opc == MOV_STORE) && (base_reg == reg_field);
    if (op_t'(op) == OP_REG_REG) begin
      kind = KIND_DIRECT;
      offs = '0;
    end else begin
      kind = (kind_t'(base_kind) == KIND_OTHER) ? KIND_ABS : kind_t'(base_kind);
      offs = offset;
    end
    match = elide_en && (opc == MOV_LOAD) && at_end_r && (kind == trk_kind_r)
            && ((kind == KIND_ABS) || (base_reg == trk_breg_r))
            && ((kind == KIND_DIRECT) || (offs == trk_off_r));
    elide_same = match && (reg_field == trk_reg_r);
    elide_move = match && (reg_field != trk_reg_r);
    emit = !drop_self && !elide_same;

    e_opc = elide_move ? MOV_STORE : opc;
    e_reg = elide_move ? trk_reg_r : reg_field;
    e_kind = elide_move ? KIND_DIRECT : kind;
    e_breg = elide_move ? reg_field : base_reg;
    e_off = elide_move ? 32'd0 : offs;

    has_modrm = (e_opc[15:12] != FORM_OPC_ONLY);
    mreg = (e_opc[15:12] == FORM_FIXED_REG) ? e_opc[10:8] : e_reg;
    fits8 = (e_off[31:7] == '0) || (e_off[31:7] == '1);
    far = (e_kind == KIND_BASE) && (e_breg == REG_EBX) && !fits8;
    disp = far ? (e_off + state_base) : e_off;
    if (e_kind == KIND_DIRECT) begin
      modv = MOD_REGISTER;
      rm = e_breg;
      dsz = 3'd0;
    end else if ((e_kind == KIND_ABS) || far) begin
      modv = MOD_INDIRECT;
      rm = REG_EBP;
      dsz = 3'd4;
    end else if ((e_off == '0) && (e_breg != REG_EBP)) begin
      modv = MOD_INDIRECT;
      rm = e_breg;
      dsz = 3'd0;
    end else if (fits8) begin
      modv = MOD_DISP8;
      rm = e_breg;
      dsz = 3'd1;
    end else begin
      modv = MOD_DISP32;
      rm = e_breg;
      dsz = 3'd4;
    end

    b = '0;
    n = '0;
    if (e_opc[19:16] != 4'h0) begin
      b[n[IDX_W-1:0]] = PREFIX_0F;
      n = n + 1'b1;
    end
    b[n[IDX_W-1:0]] = e_opc[7:0];
    n = n + 1'b1;
    if (has_modrm) begin
      b[n[IDX_W-1:0]] = {modv, mreg, rm};
      n = n + 1'b1;
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < dsz) begin
          b[n[IDX_W-1:0]] = disp[8*k +: 8];
          n = n + 1'b1;
        end
      end
    end
  end

  assign push = accept && emit;
  assign entry.bytes = b;
  assign entry.count = n;

  always_comb begin
    pos_nxt = pos_r;
    store_end_nxt = store_end_r;
    store_valid_nxt = store_valid_r;
    at_end_nxt = at_end_r;
    trk_reg_nxt = trk_reg_r;
    trk_kind_nxt = trk_kind_r;
    trk_breg_nxt = trk_breg_r;
    trk_off_nxt = trk_off_r;
    if (push) begin
      pos_nxt = pos_r + ADDRESS_WIDTH'(n);
      trk_reg_nxt = e_reg;
      trk_kind_nxt = e_kind;
      trk_breg_nxt = e_breg;
      trk_off_nxt = (e_kind == KIND_DIRECT) ? 32'd0 : e_off;
      if (e_opc == MOV_STORE) begin
        store_end_nxt = pos_nxt;
        store_valid_nxt = 1'b1;
        at_end_nxt = 1'b1;
      end else begin
        at_end_nxt = store_valid_r && (pos_nxt == store_end_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      store_end_r <= '1;
      store_valid_r <= 1'b0;
      at_end_r <= 1'b0;
      trk_reg_r <= '0;
      trk_kind_r <= KIND_BASE;
      trk_breg_r <= '0;
      trk_off_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      store_end_r <= store_end_nxt;
      store_valid_r <= store_valid_nxt;
      at_end_r <= at_end_nxt;
      trk_reg_r <= trk_reg_nxt;
      trk_kind_r <= trk_kind_nxt;
      trk_breg_r <= trk_breg_nxt;
      trk_off_r <= trk_off_nxt;
    end
  end

endmodule

@@ src/xmie_fifo.sv @@
module xmie_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  xmie_pkg::entry_t     wr_data,
  input  logic                 pop,
  output xmie_pkg::entry_t     rd_data,
  output xmie_pkg::fifo_stat_t stat
);
  import xmie_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

  entry_t mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full = (occ_r == OCC_W'(FIFO_DEPTH));
  assign stat.empty = (occ_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    occ_nxt = occ_r;
    if (push && !pop) occ_nxt = occ_r + 1'b1;
    else if (pop && !push) occ_nxt = occ_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r <= occ_nxt;
    end
  end

endmodule

@@ src/xmie_back.sv @@
module xmie_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xmie_pkg::entry_t     rd_data,
  input  xmie_pkg::fifo_stat_t stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);
  import xmie_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic last_r, last_nxt;
  logic load, final_byte;

  always_comb begin
    load = !stat.empty && (!valid_r || out_tready);
    final_byte = (CNT_W'(idx_r) == rd_data.count - 1'b1);
    pop = load && final_byte;
    idx_nxt = idx_r;
    valid_nxt = valid_r && !out_tready;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt = rd_data.bytes[idx_r];
      last_nxt = final_byte;
      idx_nxt = final_byte ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata = byte_r;
  assign out_tlast = last_r;

endmodule

@@ src/x86_modrm_instruction_emitter.sv @@
// Channel | Dir | Signals                        | Item
// in_     | in  | tvalid tready tdata[63:0] tuser | one instruction request
// out_    | out | tvalid tready tdata[7:0] tlast  | one instruction byte
// cfg_    | in  | we index[0:0] wdata[31:0]       | register write
// A request is classified and encoded in its accept cycle and queued as a whole run,
// unless it is dropped. The output serializer then sends one byte per cycle while
// out_tready is high; a request yields zero to seven bytes.
// A two-entry run queue lets new requests enter while earlier bytes stall.
// Reset is synchronous; the block is ready in the cycle after reset is released.
module x86_modrm_instruction_emitter #(
  parameter int ADDRESS_WIDTH = xmie_pkg::ADDRESS_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[23:0], reg_field[26:24], base_kind[28:27], base_reg[31:29], offset[63:32]
  input  logic [63:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import xmie_pkg::*;

  logic elide_en_r;
  logic [31:0] state_base_r;
  logic accept, fe_push, be_pop;
  entry_t fe_entry, q_entry;
  fifo_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elide_en_r <= 1'b0;
      state_base_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RELOAD_ELISION) elide_en_r <= cfg_wdata[0];
      if (cfg_index == CFG_STATE_BASE) state_base_r <= cfg_wdata;
    end
  end

  assign in_tready = !q_stat.full;
  assign accept = in_tvalid && in_tready;

  xmie_front #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_tuser),
    .opcode     (in_tdata[23:0]),
    .reg_field  (in_tdata[26:24]),
    .base_kind  (in_tdata[28:27]),
    .base_reg   (in_tdata[31:29]),
    .offset     (in_tdata[63:32]),
    .elide_en   (elide_en_r),
    .state_base (state_base_r),
    .push       (fe_push),
    .entry      (fe_entry)
  );

  xmie_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .wr_data (fe_entry),
    .pop     (be_pop),
    .rd_data (q_entry),
    .stat    (q_stat)
  );

  xmie_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_data    (q_entry),
    .stat       (q_stat),
    .pop        (be_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fe_push |-> !q_stat.full) else $error("run pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    be_pop |-> !q_stat.empty) else $error("run popped from an empty queue");

  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    fe_push |-> (fe_entry.count != '0) && (fe_entry.count <= CNT_W'(MAX_BYTES)))
    else $error("queued run has an invalid byte count");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    be_pop |=> out_tvalid && out_tlast) else $error("run ended without a last byte");

endmodule

@@ sim/x86_modrm_instruction_emitter_tb.sv @@
`timescale 1ns / 1ps

module x86_modrm_instruction_emitter_tb;
  import xmie_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RELOAD_ROWS_FROM = 19;
  localparam int PHASE_ITEMS = 86;

  typedef struct packed {
    op_t         op;
    logic [23:0] opcode;
    logic [2:0]  reg_field;
    kind_t       base_kind;
    logic [2:0]  base_reg;
    logic [31:0] offset;
  } request_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last_flag;
  } run_byte_t;

  typedef struct {
    request_t                      rq;
    int                            typed_n;
    logic [0:MAX_BYTES-1][7:0]     typed_run;
  } directed_row_t;

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_CADENCE} rx_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic        reload_elide = 1'b0;
  logic [31:0] state_base = '0;
  logic [31:0] code_pos = '0;
  logic [31:0] store_end = '1;
  logic        store_valid = 1'b0;
  logic [2:0]  trk_reg = '0;
  logic [1:0]  trk_kind = '0;
  logic [2:0]  trk_breg = '0;
  logic [31:0] trk_off = '0;

  run_byte_t     pending_bytes[$];
  run_byte_t     oldest_byte;
  directed_row_t directed_rows[$];
  int unsigned   failures = 0;
  int unsigned   requests_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  int unsigned   idle_cycles = 0;
  logic          long_hold_req = 1'b0;

  x86_modrm_instruction_emitter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned encode_request(input request_t rq,
                                                 output logic [0:MAX_BYTES-1][7:0] run);
    logic [23:0] opc;
    logic [2:0]  rg, br, rmf;
    logic [1:0]  kd, md;
    logic [31:0] off, disp;
    logic        near8;
    int unsigned dsz, n, k;
    opc = rq.opcode;
    rg = rq.reg_field;
    kd = rq.base_kind;
    br = rq.base_reg;
    off = rq.offset;
    run = '0;
    n = 0;
    dsz = 0;
    case (rq.op)
      OP_READ: opc[1] = 1'b1;
      OP_WRITE: opc[1] = 1'b0;
      OP_REG_REG: begin
        if (opc[15:12] == FORM_PLAIN) opc[1] = 1'b0;
        if (opc == MOV_STORE && br == rg) return 0;
        kd = KIND_DIRECT;
        off = '0;
      end
      default: ;
    endcase
    if (kd == KIND_OTHER) kd = KIND_ABS;
    if (reload_elide && opc == MOV_LOAD && store_valid && code_pos == store_end &&
        kd == trk_kind && (kd == KIND_ABS || br == trk_breg) &&
        (kd == KIND_DIRECT || off == trk_off)) begin
      if (rg == trk_reg) return 0;
      opc = MOV_STORE;
      br = rg;
      rg = trk_reg;
      kd = KIND_DIRECT;
      off = '0;
    end
    trk_reg = rg;
    trk_kind = kd;
    trk_breg = br;
    trk_off = (kd == KIND_DIRECT) ? 32'd0 : off;
    if (opc[19:16] != 4'h0) begin
      run[n] = PREFIX_0F;
      n++;
    end
    run[n] = opc[7:0];
    n++;
    if (opc[15:12] != FORM_OPC_ONLY) begin
      if (opc[15:12] == FORM_FIXED_REG) rg = opc[10:8];
      disp = off;
      near8 = ($signed(off) >= -128) && ($signed(off) <= 127);
      if (kd == KIND_BASE && br == REG_EBX && !near8) begin
        kd = KIND_ABS;
        disp = off + state_base;
      end
      if (kd == KIND_DIRECT) begin
        md = MOD_REGISTER;
        rmf = br;
      end else if (kd == KIND_ABS) begin
        md = MOD_INDIRECT;
        rmf = REG_EBP;
        dsz = 4;
      end else begin
        rmf = br;
        if (off == 0 && br != REG_EBP) begin
          md = MOD_INDIRECT;
        end else if (near8) begin
          md = MOD_DISP8;
          dsz = 1;
        end else begin
          md = MOD_DISP32;
          dsz = 4;
        end
      end
      run[n] = {md, rg, rmf};
      n++;
      for (k = 0; k < dsz; k++) begin
        run[n] = disp[8*k +: 8];
        n++;
      end
    end
    code_pos = code_pos + n;
    if (opc == MOV_STORE) begin
      store_end = code_pos;
      store_valid = 1'b1;
    end
    return n;
  endfunction

  function automatic request_t make_request(input op_t op, input logic [23:0] opcode,
                                            input logic [2:0] rg, input kind_t kd,
                                            input logic [2:0] br, input logic [31:0] off);
    request_t rq;
    rq.op = op;
    rq.opcode = opcode;
    rq.reg_field = rg;
    rq.base_kind = kd;
    rq.base_reg = br;
    rq.offset = off;
    return rq;
  endfunction

  function automatic directed_row_t request_row(input op_t op, input logic [23:0] opcode,
                                                input logic [2:0] rg, input kind_t kd,
                                                input logic [2:0] br, input logic [31:0] off,
                                                input int typed_n,
                                                input logic [0:MAX_BYTES-1][7:0] typed_run);
    directed_row_t row;
    row.rq = make_request(op, opcode, rg, kd, br, off);
    row.typed_n = typed_n;
    row.typed_run = typed_run;
    return row;
  endfunction

  function automatic logic [31:0] random_offset();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return {{24{b[7]}}, b};
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'd127;
          1: return 32'hFFFF_FF80;
          2: return 32'd128;
          3: return 32'hFFFF_FF7F;
          4: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      3: return {24'd0, b};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] random_opcode();
    logic [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 4))
      0: ;
      1: v = MOV_STORE;
      2: v = MOV_LOAD;
      default: begin
        if ($urandom_range(0, 3) != 0) v[23:20] = 4'h0;
        if ($urandom_range(0, 1) != 0) v[19:16] = 4'h0;
        v[15:12] = 4'($urandom_range(0, 2));
      end
    endcase
    return v;
  endfunction

  function automatic request_t random_request();
    return make_request(op_t'(2'($urandom_range(0, 3))), random_opcode(),
                        3'($urandom_range(0, 7)), kind_t'(2'($urandom_range(0, 3))),
                        3'($urandom_range(0, 7)), random_offset());
  endfunction

  task automatic send_request(input request_t rq, input int typed_n,
                              input logic [0:MAX_BYTES-1][7:0] typed_run);
    logic [0:MAX_BYTES-1][7:0] run;
    run_byte_t   rb;
    int unsigned n, k;
    if (gap_left != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_tvalid <= 1'b1;
    in_tuser <= rq.op;
    in_tdata <= {rq.offset, rq.base_reg, rq.base_kind, rq.reg_field, rq.opcode};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    n = encode_request(rq, run);
    if (typed_n >= 0) begin
      n = typed_n;
      run = typed_run;
    end
    for (k = 0; k < n; k++) begin
      rb.value = run[k];
      rb.last_flag = (k == n - 1);
      pending_bytes.push_back(rb);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
  endtask

  task automatic issue(input request_t rq);
    send_request(rq, -1, '0);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic elide, input logic [31:0] base);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RELOAD_ELISION;
    cfg_wdata <= {31'd0, elide};
    @(posedge clk);
    cfg_index <= CFG_STATE_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
    reload_elide = elide;
    state_base = base;
  endtask

  task automatic store_then_load();
    request_t st, ld;
    st = random_request();
    case ($urandom_range(0, 2))
      0: begin
        st.op = OP_WRITE;
        st.opcode = ($urandom_range(0, 1) != 0) ? MOV_STORE : MOV_LOAD;
      end
      1: begin
        st.op = OP_REG_REG;
        st.opcode = MOV_STORE;
      end
      default: begin
        st.op = OP_RAW;
        st.opcode = MOV_STORE;
      end
    endcase
    ld = st;
    ld.op = OP_READ;
    ld.opcode = ($urandom_range(0, 1) != 0) ? MOV_STORE : MOV_LOAD;
    if (st.op == OP_REG_REG) ld.base_kind = KIND_DIRECT;
    if (ld.base_kind == KIND_DIRECT) ld.offset = random_offset();
    if ($urandom_range(0, 1) != 0) ld.reg_field = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 5) == 0) ld.offset = ld.offset ^ (32'd1 << $urandom_range(0, 31));
    if ($urandom_range(0, 7) == 0) ld.base_reg = 3'($urandom_range(0, 7));
    issue(st);
    if ($urandom_range(0, 5) == 0) issue(random_request());
    issue(ld);
  endtask

  task automatic run_random_phase(input logic elide, input logic [31:0] base,
                                  input bit with_hold);
    int unsigned start;
    bit          hold_done, pause_done;
    drain_and_settle();
    apply_settings(elide, base);
    start = requests_sent;
    hold_done = 1'b0;
    pause_done = 1'b0;
    while (requests_sent - start < PHASE_ITEMS) begin
      if (with_hold && !hold_done && requests_sent - start >= 12) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!with_hold && !pause_done && requests_sent - start >= PHASE_ITEMS / 2) begin
        drain_and_settle();
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 9) < 5) begin
        store_then_load();
      end else begin
        issue(random_request());
      end
    end
  endtask

  initial begin
    rx_mode_t    mode;
    int unsigned left, tick;
    left = 0;
    tick = 0;
    mode = RX_OPEN;
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        tick++;
        case (mode)
          RX_OPEN: out_tready <= 1'b1;
          RX_HALF: out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (tick % 5 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h, out_tlast %b", out_tdata, out_tlast);
        failures++;
      end else begin
        oldest_byte = pending_bytes.pop_front();
        if (out_tdata !== oldest_byte.value) begin
          $error("out_byte: expected %h, actual %h", oldest_byte.value, out_tdata);
          failures++;
        end
        if (out_tlast !== oldest_byte.last_flag) begin
          $error("last: expected %b, actual %b", oldest_byte.last_flag, out_tlast);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("x86_modrm_instruction_emitter_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned i;
    directed_rows.push_back(request_row(OP_WRITE, 24'h000089, 3'd0, KIND_BASE, 3'd0, 32'd0,
                                        2, {8'h89, 8'h00, 40'd0}));
    directed_rows.push_back(request_row(OP_READ, 24'h00008B, 3'd7, KIND_DIRECT, 3'd7, 32'd0,
                                        2, {8'h8B, 8'hFF, 40'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000001, 3'd0, KIND_ABS, 3'd0,
                                        32'hFFFF_FFFF, 6, {8'h01, 8'h05, 32'hFFFF_FFFF, 8'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h0F00FF, 3'd7, KIND_ABS, 3'd0,
                                        32'h8000_0000, 7, {8'h0F, 8'hFF, 8'h3D, 32'h0000_0080}));
    directed_rows.push_back(request_row(OP_RAW, 24'h0020C3, 3'd5, KIND_BASE, 3'd1, 32'd9,
                                        1, {8'hC3, 48'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h0F2080, 3'd5, KIND_ABS, 3'd1, 32'd9,
                                        2, {8'h0F, 8'h80, 40'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h0017F7, 3'd0, KIND_DIRECT, 3'd3, 32'd0,
                                        2, {8'hF7, 8'hFB, 40'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_BASE, 3'd5, 32'd0,
                                        3, {8'h03, 8'h45, 8'h00, 32'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_BASE, 3'd0, 32'd127,
                                        3, {8'h03, 8'h40, 8'h7F, 32'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_BASE, 3'd0,
                                        32'hFFFF_FF80, 3, {8'h03, 8'h40, 8'h80, 32'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_BASE, 3'd1, 32'd128,
                                        6, {8'h03, 8'h81, 32'h8000_0000, 8'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_BASE, 3'd1,
                                        32'hFFFF_FF7F, 6, {8'h03, 8'h81, 32'h7FFF_FFFF, 8'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_BASE, 3'd3, 32'd128,
                                        6, {8'h03, 8'h05, 32'h8000_0000, 8'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_BASE, 3'd4, 32'd0,
                                        2, {8'h03, 8'h04, 40'd0}));
    directed_rows.push_back(request_row(OP_RAW, 24'h000003, 3'd0, KIND_OTHER, 3'd0,
                                        32'h1234_5678, 6, {8'h03, 8'h05, 32'h7856_3412, 8'd0}));
    directed_rows.push_back(request_row(OP_REG_REG, 24'h000089, 3'd2, KIND_BASE, 3'd2,
                                        32'd0, 0, '0));
    directed_rows.push_back(request_row(OP_REG_REG, 24'h00008B, 3'd1, KIND_ABS, 3'd2,
                                        32'd77, 2, {8'h89, 8'hCA, 40'd0}));
    directed_rows.push_back(request_row(OP_REG_REG, 24'h00108B, 3'd1, KIND_BASE, 3'd2,
                                        32'd0, -1, '0));
    directed_rows.push_back(request_row(OP_RAW, 24'hFFFFFF, 3'd7, KIND_BASE, 3'd7,
                                        32'h7FFF_FFFF, -1, '0));
    directed_rows.push_back(request_row(OP_WRITE, 24'h000089, 3'd2, KIND_BASE, 3'd6, 32'd8,
                                        -1, '0));
    directed_rows.push_back(request_row(OP_READ, 24'h00008B, 3'd2, KIND_BASE, 3'd6, 32'd8,
                                        0, '0));
    directed_rows.push_back(request_row(OP_READ, 24'h000089, 3'd5, KIND_BASE, 3'd6, 32'd8,
                                        2, {8'h89, 8'hD5, 40'd0}));
    directed_rows.push_back(request_row(OP_WRITE, 24'h000089, 3'd1, KIND_BASE, 3'd3,
                                        32'h0000_0100, -1, '0));
    directed_rows.push_back(request_row(OP_READ, 24'h00008B, 3'd1, KIND_BASE, 3'd3,
                                        32'h0000_0100, 0, '0));
    directed_rows.push_back(request_row(OP_READ, 24'h00008B, 3'd0, KIND_ABS, 3'd3, 32'd0,
                                        -1, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apply_settings(1'b0, 32'd0);
    for (i = 0; i < directed_rows.size(); i++) begin
      if (i == RELOAD_ROWS_FROM) begin
        drain_and_settle();
        apply_settings(1'b1, 32'hFFFF_FFFF);
      end
      send_request(directed_rows[i].rq, directed_rows[i].typed_n, directed_rows[i].typed_run);
    end

    run_random_phase(1'b0, $urandom, 1'b0);
    run_random_phase(1'b1, 32'd0, 1'b1);
    run_random_phase(1'b1, $urandom, 1'b0);
    run_random_phase(1'b0, 32'h8000_0000, 1'b0);
    drain_and_settle();

    if (failures == 0) begin
      $display("x86_modrm_instruction_emitter_tb passed");
    end else begin
      $display("x86_modrm_instruction_emitter_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/xmie_pkg.sv
src/xmie_front.sv
src/xmie_fifo.sv
src/xmie_back.sv
src/x86_modrm_instruction_emitter.sv
sim/x86_modrm_instruction_emitter_tb.sv
